/* hw/rtl/assert_macros.svh */
// Assertion macros included by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active-low reset).
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Clocked check without reset qualification.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* hw/rtl/bed_pkg.sv */
// Shared types and constants for the backslash escape decoder.
`timescale 1ns / 1ps
package bed_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT   = 2'd2
  } mode_t;

  localparam logic [7:0] BSLASH = 8'h5C;

  typedef struct packed {
    logic       string_end;
    logic       run_last;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

/* hw/rtl/bed_core.sv */
// Decode state machine: holds escape/octal state, forms up to two results per byte.
`timescale 1ns / 1ps
module bed_core
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic [7:0] in_byte,
  input  logic       in_fin,
  output step_t      step,
  output mode_t      mode
);

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  mode_t      mode_r, mode_nxt;
  logic [8:0] acc_r, acc_nxt;
  logic [1:0] dig_r, dig_nxt;

  logic       is_oct;
  logic [2:0] dval;
  logic [1:0] dig_inc;
  logic       bs_hold;
  logic       map_hit;
  logic [7:0] map_code;
  logic [1:0] n;
  logic [7:0] b0, b1;

  assign is_oct  = (in_byte[7:3] == 5'b00110);
  assign dval    = in_byte[2:0];
  assign dig_inc = dig_r + 2'd1;
  assign bs_hold = (in_byte == BSLASH) && !in_fin;

  always_comb begin
    map_hit  = 1'b1;
    map_code = in_byte;
    unique case (in_byte)
      8'h61: map_code = 8'd7;
      8'h62: map_code = 8'd8;
      8'h65: map_code = 8'd27;
      8'h66: map_code = 8'd12;
      8'h6E: map_code = 8'd10;
      8'h72: map_code = 8'd13;
      8'h74: map_code = 8'd9;
      8'h76: map_code = 8'd11;
      BSLASH, CH_QUOTE, CH_DQUOTE: map_code = in_byte;
      default: map_hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    unique case (mode_r)
      MODE_ESC: begin
        if (is_oct) begin
          acc_nxt  = {6'b0, dval};
          dig_nxt  = 2'd1;
          mode_nxt = in_fin ? MODE_PLAIN : MODE_OCT;
        end else begin
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          acc_nxt = {acc_r[5:0], dval};
          dig_nxt = dig_inc;
          if (dig_inc == 2'd3 || in_fin) mode_nxt = MODE_PLAIN;
        end else begin
          mode_nxt = bs_hold ? MODE_ESC : MODE_PLAIN;
        end
      end
      default: mode_nxt = bs_hold ? MODE_ESC : MODE_PLAIN;
    endcase
    if (mode_nxt == MODE_PLAIN || in_fin) begin
      mode_nxt = MODE_PLAIN;
      acc_nxt  = 9'd0;
      dig_nxt  = 2'd0;
    end
  end

  // outputs
  always_comb begin
    n  = 2'd0;
    b0 = in_byte;
    b1 = in_byte;
    unique case (mode_r)
      MODE_ESC: begin
        if (is_oct) begin
          n  = in_fin ? 2'd1 : 2'd0;
          b0 = {5'b0, dval};
        end else if (map_hit) begin
          n  = 2'd1;
          b0 = map_code;
        end else begin
          n  = 2'd2;
          b0 = BSLASH;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          n  = (dig_inc == 2'd3 || in_fin) ? 2'd1 : 2'd0;
          b0 = {acc_r[4:0], dval};
        end else begin
          n  = bs_hold ? 2'd1 : 2'd2;
          b0 = acc_r[7:0];
        end
      end
      default: n = bs_hold ? 2'd0 : 2'd1;
    endcase
    step.n             = n;
    step.r0.data       = b0;
    step.r0.run_last   = (n == 2'd1);
    step.r0.string_end = (n == 2'd1) && in_fin;
    step.r1.data       = b1;
    step.r1.run_last   = 1'b1;
    step.r1.string_end = in_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= 9'd0;
      dig_r  <= 2'd0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dig_r  <= dig_nxt;
    end
  end

  assign mode = mode_r;

endmodule

/* hw/rtl/bed_outq.sv */
// Three-entry shifting result queue between the decoder and the output channel.
`timescale 1ns / 1ps
module bed_outq
  import bed_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  step_t step,
  input  logic  pop,
  output res_t  head,
  output logic  head_vld,
  output logic  room
);

  res_t       q_r [3];
  res_t       q_nxt [3];
  res_t       sh [3];
  logic [1:0] cnt_r, cnt_nxt, cnt_p;

  always_comb begin
    sh[0] = pop ? q_r[1] : q_r[0];
    sh[1] = pop ? q_r[2] : q_r[1];
    sh[2] = q_r[2];
    cnt_p = cnt_r - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = sh[i];
      if (push && step.n != 2'd0 && cnt_p == 2'(i)) q_nxt[i] = step.r0;
      if (push && step.n == 2'd2 && (cnt_p + 2'd1) == 2'(i)) q_nxt[i] = step.r1;
    end
    cnt_nxt = cnt_p + (push ? step.n : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) q_r[i] <= q_nxt[i];
  end

  assign head     = q_r[0];
  assign head_vld = (cnt_r != 2'd0);
  assign room     = (cnt_r <= 2'd1);

endmodule

/* hw/rtl/backslash_escape_decoder.sv */
// Top level of the backslash escape decoder: stream in raw bytes, stream out decoded bytes.
// A result is written into the registered result queue when its input byte is taken.
// Throughput: one byte per cycle while the result queue holds at most one entry; a byte giving two results
// can take in_tready low, set by the single-read output of the three-entry result queue.
// Reset: rst_n synchronous active low; clears decode state and empties the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] run_last
  output logic       out_tlast   // string_end
);

  logic  in_acc;
  logic  out_acc;
  step_t step;
  mode_t mode;
  res_t  head;
  logic  room;

  assign in_tready = room;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  bed_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_tdata),
    .in_fin  (in_tlast),
    .step    (step),
    .mode    (mode)
  );

  bed_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_acc),
    .step     (step),
    .pop      (out_acc),
    .head     (head),
    .head_vld (out_tvalid),
    .room     (room)
  );

  assign out_tdata = head.data;
  assign out_tuser = head.run_last;
  assign out_tlast = head.string_end;

  `ASSERT_RST(a_fin_resets_mode, clk, rst_n, (in_acc && in_tlast) |=> (mode == MODE_PLAIN))
  `ASSERT_RST(a_fin_gives_result, clk, rst_n, (in_acc && in_tlast) |=> out_tvalid)
  `ASSERT_RST(a_esc_after_bslash, clk, rst_n, ($past(rst_n) && $past(in_acc) && mode == MODE_ESC) |-> ($past(in_tdata) == BSLASH))
  `ASSERT_RST(a_end_is_run_last, clk, rst_n, (out_tvalid && out_tlast) |-> out_tuser)

endmodule

/* verif/tb_backslash_escape_decoder.sv */
// Self-checking stream testbench for the backslash escape decoder.
`timescale 1ns / 1ps
module tb_backslash_escape_decoder;
  import bed_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 1250;
  localparam int unsigned HOLD_AT = 150;
  localparam int unsigned HOLD_LEN = 90;
  localparam logic [7:0] OCT_LO = "0";
  localparam logic [7:0] OCT_HI = "7";

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  raw_byte_t   raw_q[$];
  res_t        decoded_q[$];
  raw_byte_t   nxt;
  int unsigned in_taken = 0;
  int unsigned out_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic [1:0]  pace_phase = 2'd0;

  // decoder state mirror
  mode_t      dec_mode = MODE_PLAIN;
  logic [8:0] oct_val = '0;
  logic [1:0] oct_cnt = '0;

  backslash_escape_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] ob[2];
    logic [7:0] c;
    int         n;
    logic       as_plain;
    logic       is_oct;
    res_t       r;
    n = 0;
    as_plain = 1'b0;
    is_oct = (b >= OCT_LO) && (b <= OCT_HI);
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_PLAIN;
        if (is_oct) begin
          oct_val = {6'd0, b[2:0]};
          oct_cnt = 2'd1;
          if (fin) begin
            ob[n] = oct_val[7:0];
            n++;
          end else begin
            dec_mode = MODE_OCT;
          end
        end else begin
          c = b;
          case (b)
            "a": c = 8'd7;
            "b": c = 8'd8;
            "e": c = 8'd27;
            "f": c = 8'd12;
            "n": c = 8'd10;
            "r": c = 8'd13;
            "t": c = 8'd9;
            "v": c = 8'd11;
            BSLASH, "'", "\"": c = b;
            default: begin
              ob[n] = BSLASH;
              n++;
            end
          endcase
          ob[n] = c;
          n++;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          oct_val = {oct_val[5:0], b[2:0]};
          oct_cnt = oct_cnt + 2'd1;
          if (oct_cnt == 2'd3 || fin) begin
            ob[n] = oct_val[7:0];
            n++;
            dec_mode = MODE_PLAIN;
          end
        end else begin
          ob[n] = oct_val[7:0];
          n++;
          dec_mode = MODE_PLAIN;
          as_plain = 1'b1;
        end
      end
      default: begin
        dec_mode = MODE_PLAIN;
        as_plain = 1'b1;
      end
    endcase
    if (as_plain) begin
      if (b == BSLASH && !fin) begin
        dec_mode = MODE_ESC;
      end else begin
        ob[n] = b;
        n++;
      end
    end
    if (dec_mode == MODE_PLAIN || fin) begin
      oct_val = '0;
      oct_cnt = '0;
    end
    if (fin) dec_mode = MODE_PLAIN;
    for (int k = 0; k < n; k++) begin
      r.data = ob[k];
      r.run_last = (k == n - 1);
      r.string_end = (k == n - 1) && fin;
      decoded_q.push_back(r);
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    raw_q.push_back('{data: b, fin: 1'b0});
  endtask

  task automatic end_string();
    raw_q[raw_q.size() - 1].fin = 1'b1;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        in_taken++;
        pace_phase <= (in_taken < 420) ? 2'd0 : (in_taken < 840) ? 2'd1 : 2'd2;
      end
      if (!in_tvalid || in_tready) begin
        if (raw_q.size() > 0 && (hold_left > 0 ||
            $urandom_range(0, 99) >= ((pace_phase == 2'd0) ? 38 :
                                      (pace_phase == 2'd1) ? 46 : 0))) begin
          nxt = raw_q.pop_front();
          in_tdata <= nxt.data;
          in_tlast <= nxt.fin;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink with one long back-pressure stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_taken++;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && out_taken >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_tready <= 1'b0;
      end else begin
        out_tready <= $urandom_range(0, 99) >= ((pace_phase == 2'd0) ? 46 :
                                               (pace_phase == 2'd1) ? 38 : 0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected byte: got data=%02h run_last=%b string_end=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        if (decoded_q[0].data !== out_tdata || decoded_q[0].run_last !== out_tuser ||
            decoded_q[0].string_end !== out_tlast) begin
          mismatches++;
          $display("%0t mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                   $time, decoded_q[0].data, decoded_q[0].run_last, decoded_q[0].string_end,
                   out_tdata, out_tuser, out_tlast);
        end
        void'(decoded_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("backslash_escape_decoder verification failed");
      $finish;
    end
  end

  initial begin
    string      esc_set;
    int         len;
    int         sel;
    int         ndig;
    logic [7:0] b;
    esc_set = "abefnrtv\\'\"";

    // extremes, escapes, unknown escape, final in plain mode
    add_byte(8'h00);
    add_byte(BSLASH); add_byte("a");
    add_byte(BSLASH); add_byte("q");
    add_byte(BSLASH); add_byte(BSLASH);
    add_byte(8'hFF); end_string();
    // octal overflow, short octal ended by text, by backslash, by final byte
    add_byte(BSLASH); add_byte("7"); add_byte("7"); add_byte("7");
    add_byte(BSLASH); add_byte("0"); add_byte("x");
    add_byte(BSLASH); add_byte("7");
    add_byte(BSLASH); add_byte("n");
    add_byte(BSLASH); add_byte("1"); add_byte("2"); end_string();
    // lone trailing backslash, octal digit right after backslash as final
    add_byte(BSLASH); end_string();
    add_byte(BSLASH); add_byte("3"); end_string();

    while (raw_q.size() < RANDOM_BYTES + 25) begin
      len = $urandom_range(1, 14);
      for (int t = 0; t < len; t++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          b = 8'($urandom_range(0, 255));
          if (b == BSLASH) b = 8'hA3;
          add_byte(b);
        end else if (sel < 65) begin
          add_byte(BSLASH);
          add_byte(esc_set[$urandom_range(0, esc_set.len() - 1)]);
        end else if (sel < 85) begin
          add_byte(BSLASH);
          ndig = $urandom_range(1, 3);
          for (int d = 0; d < ndig; d++) add_byte(OCT_LO + 8'($urandom_range(0, 7)));
        end else if (sel < 93) begin
          add_byte(BSLASH);
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          add_byte(BSLASH);
        end
      end
      end_string();
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (raw_q.size() != 0 || in_tvalid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("backslash_escape_decoder verification clean");
    end else begin
      $display("backslash_escape_decoder verification failed");
    end
    $finish;
  end

endmodule
